// ----- rtl/core/gvp_pkg.sv -----
// Shared constants, stage types and step functions for the goal velocity profile block.
package gvp_pkg;

	localparam int SQ_STAGES  = 25;
	localparam int DIV_STAGES = 25;

	// squared goal distance below this counts as arrived
	localparam logic [49:0] EPS_LSQ = 50'd66;

	localparam logic [7:0] CFG_MAX_SPEED  = 8'd0;
	localparam logic [7:0] CFG_ACCEL_RATE = 8'd1;
	localparam logic [7:0] CFG_DECEL_RATE = 8'd2;
	localparam logic [7:0] CFG_TIME_STEP  = 8'd3;

	localparam logic [22:0] MAX_SPEED_RST  = 23'd25600;
	localparam logic [22:0] ACCEL_RATE_RST = 23'd64000;
	localparam logic [22:0] DECEL_RATE_RST = 23'd64000;
	localparam logic [23:0] TIME_STEP_RST  = 24'd1092;

	typedef struct packed {
		logic [26:0] rem;
		logic [24:0] root;
		logic [49:0] rad;
	} sq_st_t;

	typedef struct packed {
		logic [24:0] rem;
		logic [24:0] lo;
		logic [24:0] den;
		logic        ovf;
	} dv_st_t;

	// one result bit of the digit-by-digit integer square root
	function automatic sq_st_t sqrt_step(sq_st_t a);
		logic [28:0] rs;
		logic [28:0] tr;
		sq_st_t      r;
		rs    = {a.rem, a.rad[49:48]};
		tr    = {2'b00, a.root, 2'b01};
		r.rad = {a.rad[47:0], 2'b00};
		if (rs >= tr) begin
			r.rem  = 27'(rs - tr);
			r.root = {a.root[23:0], 1'b1};
		end else begin
			r.rem  = rs[26:0];
			r.root = {a.root[23:0], 1'b0};
		end
		return r;
	endfunction

	// one quotient bit of restoring division; quotient bits shift into lo
	function automatic dv_st_t div_step(dv_st_t a);
		logic [25:0] rs;
		logic        q;
		dv_st_t      r;
		rs    = {a.rem, a.lo[24]};
		q     = (rs >= {1'b0, a.den});
		r.rem = q ? 25'(rs - {1'b0, a.den}) : rs[24:0];
		r.lo  = {a.lo[23:0], q};
		r.den = a.den;
		r.ovf = a.ovf;
		return r;
	endfunction

endpackage

// ----- rtl/core/gvp_sqrt.sv -----
// Pipelined 50-bit integer square root, one result bit per stage.
module gvp_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [49:0] rad,
	output logic [24:0] root
);
	import gvp_pkg::*;

	sq_st_t st_s [SQ_STAGES];
	sq_st_t init;

	assign init = '{rem: '0, root: '0, rad: rad};

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= sqrt_step(init);
			for (int k = 1; k < SQ_STAGES; k++) begin
				st_s[k] <= sqrt_step(st_s[k-1]);
			end
		end
	end

	assign root = st_s[SQ_STAGES-1].root;

endmodule

// ----- rtl/core/gvp_div.sv -----
// Pipelined 58 by 25 bit unsigned divider with a 25-bit quotient and overflow flag.
module gvp_div (
	input  logic        clk,
	input  logic        en,
	input  logic [57:0] num,
	input  logic [24:0] den,
	output logic [24:0] quo,
	output logic        ovf
);
	import gvp_pkg::*;

	dv_st_t st_s [DIV_STAGES];
	dv_st_t init;
	logic [32:0] hi;

	// quotient needs more than 25 bits when the top part already reaches den
	assign hi   = num[57:25];
	assign init = '{rem: hi[24:0], lo: num[24:0], den: den, ovf: (hi >= {8'b0, den})};

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= div_step(init);
			for (int k = 1; k < DIV_STAGES; k++) begin
				st_s[k] <= div_step(st_s[k-1]);
			end
		end
	end

	assign quo = st_s[DIV_STAGES-1].lo;
	assign ovf = st_s[DIV_STAGES-1].ovf;

endmodule

// ----- rtl/core/goal_velocity_profile.sv -----
// Top level: preferred agent velocity under an accelerate and brake speed profile.
//
//  channel  dir  handshake                     payload
//  s_axis   in   s_axis_tvalid/s_axis_tready   tdata: goal, pos, vel; tuser: has_goal
//  m_axis   out  m_axis_tvalid/m_axis_tready   tdata: pref vel, speed cap; tuser: cap_valid
//  cfg      in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
// One agent per cycle unless held; pipeline of 3 input/square stages, 25 square root
// stages, 4 profile stages, 25 divider stages and the output register.
// The whole pipeline advances together; it holds while the output register is full
// and not taken, so s_axis_tready falls with it. Reset clears the valid bits and
// loads the register defaults. Configuration writes are always taken.
module goal_velocity_profile (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [143:0] s_axis_tdata,  // goal_x, goal_y, pos_x, pos_y, vel_x, vel_y
	input  logic         s_axis_tuser,  // has_goal
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [71:0]  m_axis_tdata,  // pref_vel_x, pref_vel_y, next_speed_cap, pad
	output logic         m_axis_tuser,  // cap_valid
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [23:0]  cfg_data
);
	import gvp_pkg::*;

	typedef struct packed {
		logic               go;
		logic signed [24:0] dx;
		logic signed [24:0] dy;
	} sq_sb_t;

	typedef struct packed {
		logic        go;
		logic [22:0] cap;
		logic        negx;
		logic        negy;
	} dv_sb_t;

	logic [22:0] max_speed_q, accel_rate_q, decel_rate_q;
	logic [23:0] time_step_q;
	logic [30:0] inc_q, dec_q;
	logic        en;

	// stage 1..3
	logic               vld_s1, vld_s2, vld_s3;
	logic               goal_s1, goal_s2, goal_s3;
	logic signed [24:0] dx_s1, dy_s1, dx_s2, dy_s2, dx_s3, dy_s3;
	logic signed [23:0] vx_s1, vy_s1;
	logic [49:0]        dxx_s2, dyy_s2;
	logic [47:0]        vxx_s2, vyy_s2;
	logic [49:0]        lsq_s3, vsq_s3;

	// square root section
	logic [SQ_STAGES-1:0] sqv_s;
	sq_sb_t               sqd_s [SQ_STAGES];
	sq_sb_t               sq_in;
	logic [24:0]          len_root, spd_root;

	// profile stages
	logic               vld_s4, vld_s5, vld_s6, vld_s7;
	logic               go_s4, go_s5, go_s6, go_s7;
	logic signed [24:0] dx_s4, dy_s4, dx_s5, dy_s5;
	logic [24:0]        len_s4, len_s5, len_s6, len_s7;
	logic [23:0]        spd_s4;
	logic [22:0]        cap_s4, cap_s5, cap_s6, cap_s7;
	logic [47:0]        ss_s4, ld_s4;
	logic signed [32:0] speed_s5;
	logic signed [57:0] px_s6, py_s6;
	logic               negx_s7, negy_s7;
	logic [57:0]        magx_s7, magy_s7;
	logic [31:0]        cap_sum;
	logic               brake;

	// divider section
	logic [DIV_STAGES-1:0] dvv_s;
	dv_sb_t                dvd_s [DIV_STAGES];
	logic [24:0]           qx, qy;
	logic                  ovfx, ovfy;

	// output register
	logic        out_vld_q;
	logic [23:0] pvx_q, pvy_q;
	logic        capv_q;
	logic [22:0] cap_q;

	function automatic logic [23:0] sat_q(logic neg, logic ovf, logic [24:0] mag);
		logic [23:0] r;
		if (neg) begin
			r = (ovf || mag > 25'd8388608) ? 24'h800000 : 24'(-mag);
		end else begin
			r = (ovf || mag > 25'd8388607) ? 24'h7FFFFF : mag[23:0];
		end
		return r;
	endfunction

	assign en            = ~out_vld_q | m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q  <= MAX_SPEED_RST;
			accel_rate_q <= ACCEL_RATE_RST;
			decel_rate_q <= DECEL_RATE_RST;
			time_step_q  <= TIME_STEP_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MAX_SPEED:  max_speed_q  <= cfg_data[22:0];
				CFG_ACCEL_RATE: accel_rate_q <= cfg_data[22:0];
				CFG_DECEL_RATE: decel_rate_q <= cfg_data[22:0];
				CFG_TIME_STEP:  time_step_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// rate times step, Q.8; settles long before the next item arrives
	always_ff @(posedge clk) begin
		inc_q <= 31'((48'(accel_rate_q) * 48'(time_step_q)) >> 16);
		dec_q <= 31'((48'(decel_rate_q) * 48'(time_step_q)) >> 16);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			sqv_s     <= '0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			dvv_s     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= s_axis_tvalid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			sqv_s     <= {sqv_s[SQ_STAGES-2:0], vld_s3};
			vld_s4    <= sqv_s[SQ_STAGES-1];
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			vld_s7    <= vld_s6;
			dvv_s     <= {dvv_s[DIV_STAGES-2:0], vld_s7};
			out_vld_q <= dvv_s[DIV_STAGES-1];
		end
	end

	assign sq_in = '{go: goal_s3 && (lsq_s3 >= EPS_LSQ), dx: dx_s3, dy: dy_s3};

	always_comb begin
		cap_sum = 32'(len_root[23:0] & '0) + 32'(spd_root) + 32'(inc_q);
	end

	assign brake = ({ld_s4, 1'b0} < {1'b0, ss_s4});

	always_ff @(posedge clk) begin
		if (en) begin
			goal_s1 <= s_axis_tuser;
			dx_s1   <= $signed({s_axis_tdata[23], s_axis_tdata[23:0]})
			         - $signed({s_axis_tdata[71], s_axis_tdata[71:48]});
			dy_s1   <= $signed({s_axis_tdata[47], s_axis_tdata[47:24]})
			         - $signed({s_axis_tdata[95], s_axis_tdata[95:72]});
			vx_s1   <= s_axis_tdata[119:96];
			vy_s1   <= s_axis_tdata[143:120];

			goal_s2 <= goal_s1;
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			dxx_s2  <= 50'(dx_s1 * dx_s1);
			dyy_s2  <= 50'(dy_s1 * dy_s1);
			vxx_s2  <= 48'(vx_s1 * vx_s1);
			vyy_s2  <= 48'(vy_s1 * vy_s1);

			goal_s3 <= goal_s2;
			dx_s3   <= dx_s2;
			dy_s3   <= dy_s2;
			lsq_s3  <= dxx_s2 + dyy_s2;
			vsq_s3  <= 50'(vxx_s2) + 50'(vyy_s2);

			sqd_s[0] <= sq_in;
			for (int k = 1; k < SQ_STAGES; k++) begin
				sqd_s[k] <= sqd_s[k-1];
			end

			go_s4  <= sqd_s[SQ_STAGES-1].go;
			dx_s4  <= sqd_s[SQ_STAGES-1].dx;
			dy_s4  <= sqd_s[SQ_STAGES-1].dy;
			len_s4 <= len_root;
			spd_s4 <= spd_root[23:0];
			cap_s4 <= (cap_sum > {9'b0, max_speed_q}) ? max_speed_q : cap_sum[22:0];
			ss_s4  <= 48'(spd_root[23:0]) * 48'(spd_root[23:0]);
			ld_s4  <= 48'(len_root) * 48'(decel_rate_q);

			go_s5    <= go_s4;
			dx_s5    <= dx_s4;
			dy_s5    <= dy_s4;
			len_s5   <= len_s4;
			cap_s5   <= cap_s4;
			speed_s5 <= brake ? ($signed({9'b0, spd_s4}) - $signed({2'b0, dec_q}))
			                  : $signed({10'b0, cap_s4});

			go_s6  <= go_s5;
			len_s6 <= len_s5;
			cap_s6 <= cap_s5;
			px_s6  <= 58'(speed_s5 * dx_s5);
			py_s6  <= 58'(speed_s5 * dy_s5);

			// quotient sign follows the numerator, since len is positive
			go_s7   <= go_s6;
			len_s7  <= len_s6;
			cap_s7  <= cap_s6;
			negx_s7 <= px_s6[57];
			negy_s7 <= py_s6[57];
			magx_s7 <= px_s6[57] ? 58'(-px_s6) : 58'(px_s6);
			magy_s7 <= py_s6[57] ? 58'(-py_s6) : 58'(py_s6);

			dvd_s[0] <= '{go: go_s7, cap: cap_s7, negx: negx_s7, negy: negy_s7};
			for (int k = 1; k < DIV_STAGES; k++) begin
				dvd_s[k] <= dvd_s[k-1];
			end

			capv_q <= dvd_s[DIV_STAGES-1].go;
			cap_q  <= dvd_s[DIV_STAGES-1].go ? dvd_s[DIV_STAGES-1].cap : '0;
			pvx_q  <= dvd_s[DIV_STAGES-1].go ? sat_q(dvd_s[DIV_STAGES-1].negx, ovfx, qx) : '0;
			pvy_q  <= dvd_s[DIV_STAGES-1].go ? sat_q(dvd_s[DIV_STAGES-1].negy, ovfy, qy) : '0;
		end
	end

	gvp_sqrt u_sqrt_len (.clk(clk), .en(en), .rad(lsq_s3), .root(len_root));
	gvp_sqrt u_sqrt_spd (.clk(clk), .en(en), .rad(vsq_s3), .root(spd_root));

	gvp_div u_div_x (.clk(clk), .en(en), .num(magx_s7), .den(len_s7), .quo(qx), .ovf(ovfx));
	gvp_div u_div_y (.clk(clk), .en(en), .num(magy_s7), .den(len_s7), .quo(qy), .ovf(ovfy));

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {1'b0, cap_q, pvy_q, pvx_q};
	assign m_axis_tuser  = capv_q;

endmodule

// ----- tb/tb_goal_velocity_profile.sv -----
// Testbench for goal_velocity_profile: directed and random agents checked against a predictor.
module tb_goal_velocity_profile;
	import gvp_pkg::*;

	localparam int LATENCY = 58;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [23:0] vx;
		logic [23:0] vy;
		logic        cap_ok;
		logic [22:0] cap;
	} pref_t;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [143:0] s_axis_tdata = '0;
	logic         s_axis_tuser = 0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [71:0]  m_axis_tdata;
	logic         m_axis_tuser;
	logic         cfg_valid = 0;
	logic         cfg_ready;
	logic [7:0]   cfg_index = '0;
	logic [23:0]  cfg_data = '0;

	logic [22:0] r_max_speed = MAX_SPEED_RST;
	logic [22:0] r_accel = ACCEL_RATE_RST;
	logic [22:0] r_decel = DECEL_RATE_RST;
	logic [23:0] r_step = TIME_STEP_RST;

	pref_t  pending_prefs[$];
	int     errors = 0;
	longint cycles = 0;
	bit     sink_random = 1;

	goal_velocity_profile i_dut (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [23:0] clip24(longint v);
		if (v > 8388607) v = 8388607;
		if (v < -8388608) v = -8388608;
		return v[23:0];
	endfunction

	function automatic pref_t predict_pref(logic hg, logic [23:0] gx, logic [23:0] gy,
			logic [23:0] px, logic [23:0] py, logic [23:0] vx, logic [23:0] vy);
		pref_t p;
		longint dx, dy, sx, sy, spd;
		longint unsigned lsq, len, vsq, s, cap, inc, dec;
		p = '{24'd0, 24'd0, 1'b0, 23'd0};
		dx = longint'($signed(gx)) - longint'($signed(px));
		dy = longint'($signed(gy)) - longint'($signed(py));
		sx = longint'($signed(vx));
		sy = longint'($signed(vy));
		if (!hg) return p;
		lsq = dx * dx + dy * dy;
		if (lsq < 66) return p;
		len = int_sqrt(lsq);
		vsq = sx * sx + sy * sy;
		s = int_sqrt(vsq);
		inc = (longint'(r_accel) * longint'(r_step)) >> 16;
		cap = s + inc;
		if (cap > r_max_speed) cap = r_max_speed;
		if (2 * len * r_decel < s * s) begin
			dec = (longint'(r_decel) * longint'(r_step)) >> 16;
			spd = longint'(s) - longint'(dec);
		end else begin
			spd = longint'(cap);
		end
		p.vx = clip24((spd * dx) / longint'(len));
		p.vy = clip24((spd * dy) / longint'(len));
		p.cap_ok = 1;
		p.cap = cap[22:0];
		return p;
	endfunction

	// tvalid stays high across back-to-back transfers; drain drops it
	task automatic send_agent(logic hg, logic [23:0] gx, logic [23:0] gy, logic [23:0] px,
			logic [23:0] py, logic [23:0] vx, logic [23:0] vy);
		int gap = $urandom_range(0, 17);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= hg;
		s_axis_tdata <= {vy, vx, py, px, gy, gx};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_prefs.push_back(predict_pref(hg, gx, gy, px, py, vx, vy));
		@(negedge clk);
	endtask

	// random sink stall per result
	initial begin
		int stall;
		forever begin
			@(negedge clk);
			stall = sink_random ? $urandom_range(0, 17) : 0;
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (stall > 0) begin
				m_axis_tready <= 0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		pref_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_prefs.size() == 0) begin
				$error("unexpected result %h", m_axis_tdata);
				errors++;
			end else begin
				e = pending_prefs.pop_front();
				if (m_axis_tdata[23:0] !== e.vx) begin
					$error("pref_vel_x exp %h got %h", e.vx, m_axis_tdata[23:0]);
					errors++;
				end
				if (m_axis_tdata[47:24] !== e.vy) begin
					$error("pref_vel_y exp %h got %h", e.vy, m_axis_tdata[47:24]);
					errors++;
				end
				if (m_axis_tdata[70:48] !== e.cap) begin
					$error("next_speed_cap exp %h got %h", e.cap, m_axis_tdata[70:48]);
					errors++;
				end
				if (m_axis_tuser !== e.cap_ok) begin
					$error("cap_valid exp %b got %b", e.cap_ok, m_axis_tuser);
					errors++;
				end
			end
		end
	end

	task automatic drain;
		s_axis_tvalid <= 0;
		while (pending_prefs.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [23:0] val);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_MAX_SPEED:  r_max_speed = val[22:0];
			CFG_ACCEL_RATE: r_accel = val[22:0];
			CFG_DECEL_RATE: r_decel = val[22:0];
			CFG_TIME_STEP:  r_step = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	function automatic logic [23:0] rnd_coord();
		case ($urandom_range(0, 4))
			0: return 24'($urandom());
			1: return 24'($signed($urandom_range(0, 8192)) - 4096);
			2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
			default: return 24'($signed($urandom_range(0, 262144)) - 131072);
		endcase
	endfunction

	task automatic test_directed;
		send_agent(0, 24'h001000, 0, 0, 0, 24'h000400, 0);
		send_agent(1, 24'd5, 24'd5, 0, 0, 24'd100, 0);          // inside epsilon
		send_agent(1, 24'd8, 24'd1, 0, 0, 0, 0);                // just inside epsilon
		send_agent(1, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000,
			24'h7FFFFF, 24'h7FFFFF);
		send_agent(1, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000,
			24'h800000, 24'h800000);
		send_agent(1, 24'd2560, 0, 0, 0, 0, 0);                 // accelerate from rest
		send_agent(1, 24'd256, 0, 0, 0, 24'd25600, 0);          // brake
		send_agent(1, 24'd25600, 24'd1000, 0, 0, 24'd100, 24'd100);
		send_agent(1, 24'hFFFF00, 24'hFFFE00, 0, 0, 24'hFFFF00, 0);
		drain();
		write_reg(CFG_DECEL_RATE, 0);                           // zero deceleration
		send_agent(1, 24'd5000, 0, 0, 0, 24'd1, 0);
		send_agent(1, 24'd5000, 0, 0, 0, 0, 0);
		drain();
		write_reg(CFG_DECEL_RATE, 24'd1);
		write_reg(CFG_TIME_STEP, 24'hFFFFFF);
		write_reg(CFG_ACCEL_RATE, 24'h7FFFFF);
		write_reg(CFG_MAX_SPEED, 24'hFFFFFF);                   // masked to 23 bits
		write_reg(8'd200, 24'h123456);                          // unknown index
		send_agent(1, 24'd100, 0, 0, 0, 24'd3000, 0);           // brake
		send_agent(1, 24'd9000, 24'd9000, 0, 0, 24'd1, 24'd1);
		drain();
	endtask

	task automatic test_random;
		logic [23:0] px, py, gx, gy;
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_MAX_SPEED, 24'd25600); write_reg(CFG_ACCEL_RATE, 24'd64000);
					write_reg(CFG_DECEL_RATE, 24'd64000); write_reg(CFG_TIME_STEP, 24'd1092);
				end
				1: begin
					write_reg(CFG_MAX_SPEED, 24'd0); write_reg(CFG_ACCEL_RATE, 24'd0);
					write_reg(CFG_DECEL_RATE, 24'h7FFFFF); write_reg(CFG_TIME_STEP, 24'd1);
				end
				default: begin
					write_reg(CFG_MAX_SPEED, 24'($urandom_range(0, 24'hFFFFFF)));
					write_reg(CFG_ACCEL_RATE, 24'($urandom_range(0, 24'hFFFFFF)));
					write_reg(CFG_DECEL_RATE, 24'($urandom_range(1, 23'h7FFFFF)));
					write_reg(CFG_TIME_STEP, 24'($urandom_range(1, 24'hFFFFFF)));
				end
			endcase
			sink_random = (ph != 3);
			for (int i = 0; i < 200; i++) begin
				px = rnd_coord(); py = rnd_coord();
				if ($urandom_range(0, 9) == 0) begin
					gx = px + 24'($signed($urandom_range(0, 16)) - 8);
					gy = py + 24'($signed($urandom_range(0, 16)) - 8);
				end else begin
					gx = rnd_coord(); gy = rnd_coord();
				end
				send_agent($urandom_range(0, 9) != 0, gx, gy, px, py, rnd_coord(), rnd_coord());
			end
			drain();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		repeat (2) @(negedge clk);
		test_directed();
		test_random();
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/core/gvp_pkg.sv
rtl/core/gvp_sqrt.sv
rtl/core/gvp_div.sv
rtl/core/goal_velocity_profile.sv
tb/tb_goal_velocity_profile.sv
